/* hdl/rscs_pkg.sv */
package rscs_pkg;

   localparam int MemBytesDefault = 128;

   // request func codes
   localparam logic [1:0] FuncStep = 2'd0;
   localparam logic [1:0] FuncWreg = 2'd1;
   localparam logic [1:0] FuncWmem = 2'd2;
   localparam logic [1:0] FuncRreg = 2'd3;

   // opcodes
   localparam logic [5:0] OpRtype = 6'b000000;
   localparam logic [5:0] OpLw    = 6'b100011;
   localparam logic [5:0] OpSw    = 6'b101011;
   localparam logic [5:0] OpBeq   = 6'b000100;
   localparam logic [5:0] OpJ     = 6'b000010;

   // r-type function codes
   localparam logic [5:0] FnAdd = 6'b100000;
   localparam logic [5:0] FnSub = 6'b100010;
   localparam logic [5:0] FnAnd = 6'b100100;
   localparam logic [5:0] FnOr  = 6'b100101;
   localparam logic [5:0] FnSlt = 6'b101010;

   localparam logic [25:0] JumpMask = 26'h3FFFFFF;
   localparam logic [15:0] ImmMask  = 16'hFFFF;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_AND,
      ALU_OR,
      ALU_SLT
   } alu_op_type;

   // packed so that status lands in the lowest bit
   typedef struct packed {
      logic [31:0] mem_data;
      logic [6:0]  mem_address;
      logic        mem_written;
      logic [31:0] reg_data;
      logic [4:0]  reg_number;
      logic        reg_written;
      logic        branch_taken;
      logic [31:0] instr_word;
      logic [31:0] pc_after;
      logic        status;
   } rsp_type;

   function automatic logic [31:0] alu_calc(alu_op_type op, logic [31:0] a, logic [31:0] b);
      logic [31:0] y;
      y = '0;
      unique case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         ALU_AND: y = a & b;
         ALU_OR:  y = a | b;
         ALU_SLT: y = {31'd0, ($signed(a) < $signed(b))};
         default: y = '0;
      endcase
      return y;
   endfunction

endpackage

/* hdl/risc_subset_core_step_top.sv */
// sequence: register preloads, memory byte preloads and register reads pass from dispatch to done;
// a step fetches the instruction byte by byte, reads both source registers, forms pc+4, executes,
// then branches, loads or stores; a step while halted or past memory goes straight to done and halts
// throughput: one request at a time; fetch and load share the single byte read port of the memory,
// and operand and register reads share the single read port of the register file
// reset: synchronous, clears pc, halt bit and register valid bits, then sweeps
// memory to zero one byte a cycle over all MEM_BYTES bytes before the first request
module risc_subset_core_step_top #(
   parameter int MEM_BYTES = rscs_pkg::MemBytesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // func[1:0], index[8:2], value[40:9], zero[47:41]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata    // status[0], pc_after[32:1], instr_word[64:33],
                                     // branch_taken[65], reg_written[66], reg_number[71:67],
                                     // reg_data[103:72], mem_written[104],
                                     // mem_address[111:105], mem_data[143:112]
);
   import rscs_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);
   localparam logic [31:0] MemSize  = 32'(MEM_BYTES);
   localparam logic [31:0] LastWord = 32'(MEM_BYTES - 4);
   localparam logic [AW-1:0] LastAddr = AW'(MEM_BYTES - 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DISP  = 4'd1;
   localparam logic [3:0] ST_FETCH = 4'd2;
   localparam logic [3:0] ST_RDA   = 4'd3;
   localparam logic [3:0] ST_RDB   = 4'd4;
   localparam logic [3:0] ST_PC4   = 4'd5;
   localparam logic [3:0] ST_EXEC  = 4'd6;
   localparam logic [3:0] ST_BR    = 4'd7;
   localparam logic [3:0] ST_ADDR  = 4'd8;
   localparam logic [3:0] ST_LOAD  = 4'd9;
   localparam logic [3:0] ST_STORE = 4'd10;
   localparam logic [3:0] ST_RDREG = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;

   logic [3:0]  state_ff, state_in;
   logic        halted_ff, halted_in;
   logic [31:0] pc_ff, pc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        clear_ff, clear_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [31:0] rf_vld_ff;

   logic [1:0]  func_ff, func_in;
   logic [6:0]  index_ff, index_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] instr_ff, instr_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] pc4_ff, pc4_in;
   logic [31:0] ea_ff, ea_in;
   rsp_type     wrk_ff, wrk_in;
   rsp_type     rsp_ff, rsp_in;

   logic [31:0] rf_mem [32];
   logic [31:0] rf_rdata_ff;
   logic        rf_rok_ff;
   logic        rf_we;
   logic [4:0]  rf_waddr, rf_raddr;
   logic [31:0] rf_wdata, rf_rdata;

   logic [7:0]    mem_ram [MEM_BYTES];
   logic [7:0]    mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   alu_op_type  alu_op;
   logic [31:0] alu_a, alu_b, alu_y;

   logic [5:0]  opcode, fn;
   logic [4:0]  rs, rt, rd;
   logic [31:0] imm;
   logic        req_take;
   logic        fn_known;

   assign opcode = instr_ff[31:26];
   assign rs     = instr_ff[25:21];
   assign rt     = instr_ff[20:16];
   assign rd     = instr_ff[15:11];
   assign fn     = instr_ff[5:0];
   assign imm    = {{16{instr_ff[15]}}, instr_ff[15:0] & ImmMask};

   assign req_tready = (state_ff == ST_IDLE) && !clear_ff;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rf_rdata   = rf_rok_ff ? rf_rdata_ff : '0;
   assign alu_y      = alu_calc(alu_op, alu_a, alu_b);
   assign fn_known   = (fn == FnAdd) || (fn == FnSub) || (fn == FnAnd) ||
                       (fn == FnOr) || (fn == FnSlt);

   // byte read address walks up from the word base
   always_comb begin
      if (state_ff == ST_FETCH) begin
         mem_raddr = pc_ff[AW-1:0] + AW'(cnt_ff[1:0]);
      end else begin
         mem_raddr = ea_ff[AW-1:0] + AW'(cnt_ff[1:0]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      halted_in    = halted_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      clear_in     = clear_ff;
      clr_cnt_in   = clr_cnt_ff;
      func_in      = func_ff;
      index_in     = index_ff;
      value_in     = value_ff;
      instr_in     = instr_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pc4_in       = pc4_ff;
      ea_in        = ea_ff;
      wrk_in       = wrk_ff;
      rsp_in       = rsp_ff;
      rf_we        = 1'b0;
      rf_waddr     = rd;
      rf_wdata     = alu_y;
      rf_raddr     = rs;
      mem_we       = 1'b0;
      mem_waddr    = clr_cnt_ff;
      mem_wdata    = '0;
      alu_op       = ALU_ADD;
      alu_a        = a_ff;
      alu_b        = b_ff;

      if (clear_ff) begin
         mem_we     = 1'b1;
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == LastAddr) begin
            clear_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in  = req_tdata[1:0];
               index_in = req_tdata[8:2];
               value_in = req_tdata[40:9];
               instr_in = '0;
               wrk_in   = '0;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            unique case (func_ff)
               FuncStep: begin
                  if (halted_ff || (pc_ff > LastWord)) begin
                     halted_in = 1'b1;
                     state_in  = ST_DONE;
                  end else begin
                     cnt_in   = '0;
                     state_in = ST_FETCH;
                  end
               end
               FuncWreg: begin
                  if ((index_ff[6:5] == 2'd0) && (index_ff[4:0] != 5'd0)) begin
                     rf_we              = 1'b1;
                     rf_waddr           = index_ff[4:0];
                     rf_wdata           = value_ff;
                     wrk_in.reg_written = 1'b1;
                     wrk_in.reg_number  = index_ff[4:0];
                     wrk_in.reg_data    = value_ff;
                  end
                  state_in = ST_DONE;
               end
               FuncWmem: begin
                  if ({25'd0, index_ff} < MemSize) begin
                     mem_we             = 1'b1;
                     mem_waddr          = AW'({25'd0, index_ff});
                     mem_wdata          = value_ff[7:0];
                     wrk_in.mem_written = 1'b1;
                     wrk_in.mem_address = index_ff;
                     wrk_in.mem_data    = {24'd0, value_ff[7:0]};
                  end
                  state_in = ST_DONE;
               end
               FuncRreg: begin
                  rf_raddr = index_ff[4:0];
                  state_in = ST_RDREG;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_RDREG: begin
            if (index_ff[6:5] == 2'd0) begin
               wrk_in.reg_data = rf_rdata;
            end
            state_in = ST_DONE;
         end
         ST_FETCH: begin
            // read data is registered, so it trails its address into the next cycle
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff != 3'd0) begin
               word_in = {word_ff[23:0], mem_rdata_ff};
            end
            if (cnt_ff == 3'd4) begin
               instr_in = {word_ff[23:0], mem_rdata_ff};
               state_in = ST_RDA;
            end
         end
         ST_RDA: begin
            rf_raddr = rs;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            a_in     = rf_rdata;
            rf_raddr = rt;
            state_in = ST_PC4;
         end
         ST_PC4: begin
            b_in     = rf_rdata;
            alu_op   = ALU_ADD;
            alu_a    = pc_ff;
            alu_b    = 32'd4;
            pc4_in   = alu_y;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            wrk_in.instr_word = instr_ff;
            pc_in             = pc4_ff;
            state_in          = ST_DONE;
            priority case (opcode)
               OpRtype: begin
                  priority case (fn)
                     FnSub:   alu_op = ALU_SUB;
                     FnAnd:   alu_op = ALU_AND;
                     FnOr:    alu_op = ALU_OR;
                     FnSlt:   alu_op = ALU_SLT;
                     default: alu_op = ALU_ADD;
                  endcase
                  if (fn_known && (rd != 5'd0)) begin
                     rf_we              = 1'b1;
                     rf_waddr           = rd;
                     rf_wdata           = alu_y;
                     wrk_in.reg_written = 1'b1;
                     wrk_in.reg_number  = rd;
                     wrk_in.reg_data    = alu_y;
                  end
               end
               OpLw, OpSw: begin
                  alu_op   = ALU_ADD;
                  alu_b    = imm;
                  ea_in    = alu_y;
                  state_in = ST_ADDR;
               end
               OpBeq: begin
                  alu_op = ALU_SUB;
                  if (alu_y == 32'd0) begin
                     state_in = ST_BR;
                  end
               end
               OpJ: begin
                  pc_in               = {pc4_ff[31:28], instr_ff[25:0] & JumpMask, 2'b00};
                  wrk_in.branch_taken = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_BR: begin
            alu_op              = ALU_ADD;
            alu_a               = pc4_ff;
            alu_b               = {imm[29:0], 2'b00};
            pc_in               = alu_y;
            wrk_in.branch_taken = 1'b1;
            state_in            = ST_DONE;
         end
         ST_ADDR: begin
            cnt_in = '0;
            if (opcode == OpLw) begin
               if (ea_ff <= LastWord) begin
                  state_in = ST_LOAD;
               end else begin
                  // load past memory gives zero
                  if (rt != 5'd0) begin
                     rf_we              = 1'b1;
                     rf_waddr           = rt;
                     rf_wdata           = '0;
                     wrk_in.reg_written = 1'b1;
                     wrk_in.reg_number  = rt;
                     wrk_in.reg_data    = '0;
                  end
                  state_in = ST_DONE;
               end
            end else begin
               state_in = (ea_ff <= LastWord) ? ST_STORE : ST_DONE;
            end
         end
         ST_LOAD: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff != 3'd0) begin
               word_in = {word_ff[23:0], mem_rdata_ff};
            end
            if (cnt_ff == 3'd4) begin
               if (rt != 5'd0) begin
                  rf_we              = 1'b1;
                  rf_waddr           = rt;
                  rf_wdata           = {word_ff[23:0], mem_rdata_ff};
                  wrk_in.reg_written = 1'b1;
                  wrk_in.reg_number  = rt;
                  wrk_in.reg_data    = {word_ff[23:0], mem_rdata_ff};
               end
               state_in = ST_DONE;
            end
         end
         ST_STORE: begin
            // big-endian: most significant byte at the lowest address
            mem_we    = 1'b1;
            mem_waddr = ea_ff[AW-1:0] + AW'(cnt_ff[1:0]);
            unique case (cnt_ff[1:0])
               2'd0: mem_wdata = b_ff[31:24];
               2'd1: mem_wdata = b_ff[23:16];
               2'd2: mem_wdata = b_ff[15:8];
               2'd3: mem_wdata = b_ff[7:0];
               default: mem_wdata = b_ff[7:0];
            endcase
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               wrk_in.mem_written = 1'b1;
               wrk_in.mem_address = ea_ff[6:0];
               wrk_in.mem_data    = b_ff;
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in          = wrk_ff;
               rsp_in.status   = halted_ff;
               rsp_in.pc_after = pc_ff;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         halted_ff    <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         clear_ff     <= clear_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      index_ff <= index_in;
      value_ff <= value_in;
      instr_ff <= instr_in;
      word_ff  <= word_in;
      cnt_ff   <= cnt_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      pc4_ff   <= pc4_in;
      ea_ff    <= ea_in;
      wrk_ff   <= wrk_in;
      rsp_ff   <= rsp_in;
   end

   // register file: entries not yet written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[rf_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      rf_rdata_ff <= rf_mem[rf_raddr];
      rf_rok_ff   <= rf_vld_ff[rf_raddr] && (rf_raddr != 5'd0);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem_ram[mem_raddr];
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt bit dropped without reset");

   a_rf_no_zero: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (rf_waddr != 5'd0))
      else $error("write to register zero");

   a_halted_pc_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISP && func_ff == FuncStep && halted_ff) |=> $stable(pc_ff))
      else $error("pc moved while halted");

   a_rsp_regnum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.reg_written) |-> (rsp_ff.reg_number == 5'd0))
      else $error("register number without write");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_tready)
      else $error("request taken during memory clear");

endmodule
